>>> hdl/assert_macros.svh
// assertion macros used by the glyph quad generator emitter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define TGQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, checked at every rising edge outside reset
`define TGQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hdl/tgq_pkg.sv
// types, constants and helper functions of the glyph quad generator
`timescale 1ns / 1ps
`default_nettype none
package tgq_pkg;

  // handed-down parameter defaults
  localparam int INDEX_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // atlas grid, fixed at sixteen columns
  localparam int ATLAS_COLUMNS   = 16;

  // field widths
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COLOR = 3'd4;

  // register reset values
  localparam logic [30:0] GLYPH_SIZE_RST  = 31'd524288;
  localparam logic [31:0] GLYPH_COLOR_RST = 32'hFFFF_FFFF;

  // result item kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_EXTENT = 2'd2;

  // special bytes and utf-8 lead masks
  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] LEAD4_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_MASK   = 8'hC0;
  localparam logic [7:0] CONT_CODE    = 8'h80;

  // largest code point that has a glyph of its own
  localparam logic [20:0] MAX_GLYPH = 21'd256;

  // atlas cell geometry in 1/256 units
  localparam logic [8:0] CELL_U = 9'(256 / ATLAS_COLUMNS);
  localparam logic [7:0] V_SPAN = 8'd8;

  // step of the last result of a glyph
  localparam logic [STEP_W-1:0] GLYPH_LAST_STEP = 4'd9;

  // decoded command passed from front to back
  typedef enum logic [1:0] {
    CMD_GLYPH   = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_END     = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [8:0] code;
  } cmd_t;

  // queue write side and queue head
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // clamp a 33-bit signed sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // vertex offset from the quad base for each result step
  function automatic logic [1:0] index_offset(input logic [STEP_W-1:0] step);
    logic [1:0] r;
    case (step)
      4'd0:    r = 2'd0;
      4'd1:    r = 2'd1;
      4'd2:    r = 2'd2;
      4'd3:    r = 2'd3;
      4'd4:    r = 2'd0;
      4'd5:    r = 2'd2;
      4'd6:    r = 2'd1;
      4'd7:    r = 2'd0;
      4'd8:    r = 2'd3;
      4'd9:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tgq_if.sv
// channel interfaces: text byte input, result output, configuration writes
`timescale 1ns / 1ps
`default_nettype none

// text byte channel
interface tgq_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// result item channel
interface tgq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [8:0]         tex_u;
  logic [7:0]         tex_v;
  logic [31:0]        vertex_color;
  logic [15:0]        index_value;
  logic               last;
  modport source (output valid, output item_kind, output pos_x, output pos_y,
                  output pos_z, output tex_u, output tex_v, output vertex_color,
                  output index_value, output last, input ready);
  modport sink   (input valid, input item_kind, input pos_x, input pos_y,
                  input pos_z, input tex_u, input tex_v, input vertex_color,
                  input index_value, input last, output ready);
endinterface

// configuration write channel
interface tgq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/text_glyph_quad_generator.sv
// Text glyph quad generator, top level.
// Channels: "in" carries one UTF-8 text byte per item; "out" carries result
// items (vertex, index or text extent); "cfg" writes the origin, glyph size
// and colour registers and is always ready.
// Each glyph byte gives ten result items: four vertices, then six indices,
// the last flagged. A zero byte gives one extent item. Newline, lead and
// inner sequence bytes give none.
// A byte is written into the command queue when accepted, and its first result
// is loaded from the queue head into the output register. Throughput: one
// result item per cycle while the receiver keeps ready high; newline commands
// retire without output. The single output register sets this rate.
// A four-entry command queue lets the decoder keep taking bytes while the
// emitter works, so "in" stalls only when the queue is full.
// Reset (synchronous, rst high) clears decoder, queue and cursor state and
// loads the register defaults; no result is valid after reset.
// When the receiver holds ready low, the output register holds its item and
// the emitter pauses; the queue then fills and back-pressures "in".
`timescale 1ns / 1ps
`default_nettype none
module text_glyph_quad_generator
  import tgq_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tgq_byte_if.sink  in,
  tgq_cfg_if.sink   cfg,
  tgq_out_if.source out
);

  cmd_slot_t push;
  cmd_slot_t head;
  logic      full;
  logic      pop;

  // front: decode bytes into commands
  tgq_decoder u_decoder (
    .clk  (clk),
    .rst  (rst),
    .in   (in),
    .full (full),
    .push (push)
  );

  // command queue
  tgq_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // back: emit result items
  tgq_emitter #(
    .INDEX_BITS (INDEX_BITS)
  ) u_emitter (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cfg  (cfg),
    .out  (out)
  );

endmodule
`default_nettype wire

>>> hdl/tgq_decoder.sv
// front end: utf-8 decoding and classification of text bytes into commands
`timescale 1ns / 1ps
`default_nettype none
module tgq_decoder
  import tgq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tgq_byte_if.sink   in,
  input  wire logic  full,
  output cmd_slot_t  push
);

  logic [1:0]  bytes_pending;
  logic [20:0] partial_cp;
  logic [1:0]  bytes_pending_next;
  logic [20:0] partial_cp_next;
  logic        accept;
  logic [7:0]  b;
  logic [20:0] cont_cp;
  logic [1:0]  pend_dec;

  // take a byte whenever the queue has room
  assign in.ready = !full;
  assign accept   = in.valid && !full;
  assign b        = in.text_byte;

  // continuation data appended to the partial code point
  assign cont_cp  = {partial_cp[14:0], b[5:0]};
  assign pend_dec = bytes_pending - 2'd1;

  // classify the byte
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_cp_next    = partial_cp;
    push.valid         = 1'b0;
    push.cmd.kind      = CMD_GLYPH;
    push.cmd.code      = 9'd0;
    if (accept) begin
      if (b == BYTE_END) begin
        push.valid         = 1'b1;
        push.cmd.kind      = CMD_END;
        bytes_pending_next = 2'd0;
        partial_cp_next    = 21'd0;
      end else if (bytes_pending != 2'd0) begin
        bytes_pending_next = pend_dec;
        if (pend_dec == 2'd0) begin
          partial_cp_next = 21'd0;
          push.valid      = 1'b1;
          push.cmd.code   = (cont_cp > MAX_GLYPH) ? 9'd0 : cont_cp[8:0];
        end else begin
          partial_cp_next = cont_cp;
        end
      end else if (b == BYTE_NEWLINE) begin
        push.valid    = 1'b1;
        push.cmd.kind = CMD_NEWLINE;
      end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
        partial_cp_next    = {18'd0, b[2:0]};
        bytes_pending_next = 2'd3;
      end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
        partial_cp_next    = {17'd0, b[3:0]};
        bytes_pending_next = 2'd2;
      end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
        partial_cp_next    = {16'd0, b[4:0]};
        bytes_pending_next = 2'd1;
      end else if ((b & LEAD2_MASK) == CONT_CODE) begin
        // stray continuation byte
        push.valid = 1'b1;
      end else begin
        push.valid    = 1'b1;
        push.cmd.code = {1'b0, b};
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_cp    <= 21'd0;
    end else begin
      bytes_pending <= bytes_pending_next;
      partial_cp    <= partial_cp_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tgq_cmd_fifo.sv
// short command queue between decoder and emitter
`timescale 1ns / 1ps
`default_nettype none
module tgq_cmd_fifo
  import tgq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_slot_t push,
  output logic      full,
  output cmd_slot_t head,
  input  wire logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/tgq_emitter.sv
// back end: cursor state, configuration registers and result item sequencing
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tgq_emitter
  import tgq_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cmd_slot_t  head,
  output logic       pop,
  tgq_cfg_if.sink    cfg,
  tgq_out_if.source  out
);

  // configuration registers
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [30:0] glyph_size;
  logic [31:0] glyph_color;

  // text state
  logic signed [31:0]  cursor_x;
  logic signed [31:0]  cursor_y;
  logic signed [31:0]  row_width;
  logic signed [31:0]  widest_line;
  logic signed [31:0]  extent_height;
  logic [INDEX_BITS-1:0] vertex_counter;
  logic [STEP_W-1:0]   step;

  // output register
  logic        o_valid;
  logic [1:0]  o_kind;
  logic [31:0] o_x;
  logic [31:0] o_y;
  logic [31:0] o_z;
  logic [8:0]  o_u;
  logic [7:0]  o_v;
  logic [31:0] o_color;
  logic [15:0] o_index;
  logic        o_last;

  logic        can_load;
  logic        load;
  logic [32:0] size_ext;
  logic [31:0] x1;
  logic [31:0] y1;
  logic [31:0] row_width_add;
  logic [31:0] cursor_y_down;
  logic [31:0] widest_brk;
  logic [31:0] height_brk;
  logic [3:0]  col;
  logic [4:0]  row;
  logic [8:0]  u0;
  logic [8:0]  u1;
  logic [7:0]  v1;
  logic [7:0]  v0;
  logic [INDEX_BITS-1:0] idx;
  logic        x_far;
  logic        y_far;
  logic        is_glyph_pop;

  assign cfg.ready = 1'b1;

  // quad corners and line bookkeeping
  assign size_ext       = {2'b00, glyph_size};
  assign x1             = sat32({cursor_x[31], cursor_x} + size_ext);
  assign y1             = sat32({cursor_y[31], cursor_y} + size_ext);
  assign row_width_add  = sat32({row_width[31], row_width} + size_ext);
  assign cursor_y_down  = sat32({cursor_y[31], cursor_y} - size_ext);
  assign widest_brk     = (row_width > widest_line) ? row_width : widest_line;
  assign height_brk     = sat32({extent_height[31], extent_height} - size_ext);

  // atlas cell of the glyph
  assign col = head.cmd.code[3:0];
  assign row = head.cmd.code[8:4];
  assign u0  = 9'(col) * CELL_U;
  assign u1  = u0 + CELL_U;
  assign v1  = 8'({3'd0, row} << 3) + 8'({3'd0, row} << 1);
  assign v0  = v1 + V_SPAN;

  // vertex index of this step
  assign idx   = vertex_counter + INDEX_BITS'(index_offset(step));
  assign x_far = (step == 4'd2) || (step == 4'd3);
  assign y_far = (step == 4'd1) || (step == 4'd2);

  // sequencing: one result per cycle into the output register while it is free or being read
  assign can_load = !o_valid || out.ready;
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    if (head.valid) begin
      case (head.cmd.kind)
        CMD_NEWLINE: pop = 1'b1;
        CMD_END: begin
          load = can_load;
          pop  = can_load;
        end
        CMD_GLYPH: begin
          load = can_load;
          pop  = can_load && (step == GLYPH_LAST_STEP);
        end
        default: pop = 1'b1;
      endcase
    end
  end
  assign is_glyph_pop = pop && (head.cmd.kind == CMD_GLYPH);

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (out.ready) begin
      o_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      o_x     <= 32'd0;
      o_y     <= 32'd0;
      o_z     <= 32'd0;
      o_u     <= 9'd0;
      o_v     <= 8'd0;
      o_color <= 32'd0;
      o_index <= 16'd0;
      o_last  <= 1'b0;
      if (head.cmd.kind == CMD_END) begin
        o_kind <= KIND_EXTENT;
        o_x    <= widest_brk;
        o_y    <= height_brk;
        o_last <= 1'b1;
      end else if (step < 4'd4) begin
        o_kind  <= KIND_VERTEX;
        o_x     <= x_far ? x1 : cursor_x;
        o_y     <= y_far ? y1 : cursor_y;
        o_z     <= origin_z;
        o_u     <= x_far ? u1 : u0;
        o_v     <= y_far ? v1 : v0;
        o_color <= glyph_color;
        o_index <= 16'(idx);
      end else begin
        o_kind  <= KIND_INDEX;
        o_index <= 16'(idx);
        o_last  <= (step == GLYPH_LAST_STEP);
      end
    end
  end

  // text state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= 32'd0;
      origin_y       <= 32'd0;
      origin_z       <= 32'd0;
      glyph_size     <= GLYPH_SIZE_RST;
      glyph_color    <= GLYPH_COLOR_RST;
      cursor_x       <= 32'sd0;
      cursor_y       <= 32'sd0;
      row_width      <= 32'sd0;
      widest_line    <= 32'sd0;
      extent_height  <= 32'sd0;
      vertex_counter <= '0;
      step           <= '0;
    end else begin
      if (head.valid) begin
        case (head.cmd.kind)
          CMD_NEWLINE: begin
            cursor_y      <= cursor_y_down;
            cursor_x      <= origin_x;
            widest_line   <= widest_brk;
            extent_height <= height_brk;
            row_width     <= 32'sd0;
          end
          CMD_END: begin
            if (pop) begin
              cursor_x      <= origin_x;
              cursor_y      <= origin_y;
              row_width     <= 32'sd0;
              widest_line   <= 32'sd0;
              extent_height <= 32'sd0;
            end
          end
          CMD_GLYPH: begin
            if (pop) begin
              step           <= '0;
              vertex_counter <= vertex_counter + INDEX_BITS'(4);
              cursor_x       <= x1;
              row_width      <= row_width_add;
            end else if (load) begin
              step <= step + 1'b1;
            end
          end
          default: step <= '0;
        endcase
      end
      // register writes must arrive only while the block is idle; the block does not enforce this
      if (cfg.valid) begin
        case (cfg.index)
          REG_ORIGIN_X: begin
            origin_x <= cfg.data;
            cursor_x <= cfg.data;
          end
          REG_ORIGIN_Y: begin
            origin_y <= cfg.data;
            cursor_y <= cfg.data;
          end
          REG_ORIGIN_Z:    origin_z    <= cfg.data;
          REG_GLYPH_SIZE:  glyph_size  <= cfg.data[30:0];
          REG_GLYPH_COLOR: glyph_color <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // output port drive
  assign out.valid        = o_valid;
  assign out.item_kind    = o_kind;
  assign out.pos_x        = o_x;
  assign out.pos_y        = o_y;
  assign out.pos_z        = o_z;
  assign out.tex_u        = o_u;
  assign out.tex_v        = o_v;
  assign out.vertex_color = o_color;
  assign out.index_value  = o_index;
  assign out.last         = o_last;

  // step counter only runs while a glyph sits at the queue head
  `TGQ_ASSERT_IMPL(a_step_in_glyph, clk, rst, step != '0,
    head.valid && head.cmd.kind == CMD_GLYPH)
  // a glyph leaves the queue only with its final result
  `TGQ_ASSERT_IMPL(a_glyph_pop_last, clk, rst, is_glyph_pop, step == GLYPH_LAST_STEP)
  // each finished glyph consumes four vertex indices
  `TGQ_ASSERT_NEXT(a_counter_adv, clk, rst, is_glyph_pop,
    vertex_counter == $past(vertex_counter) + INDEX_BITS'(4))

endmodule
`default_nettype wire

>>> sim/tb_text_glyph_quad_generator.sv
// testbench for the text glyph quad generator: directed text table and random utf-8 streams
`timescale 1ns / 1ps
module tb_text_glyph_quad_generator;
  import tgq_pkg::*;

  localparam int    RUN_LIMIT    = 300000;
  localparam int    DRAIN_CYCLES = 30;
  localparam int    PHASES       = 6;
  localparam int    PHASE_BYTES  = 20;
  localparam int    CELL_W       = 256 / ATLAS_COLUMNS;
  localparam int    ROW_PITCH    = 10;
  localparam int    ROW_INK      = 8;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  // corner order of the two triangles of a quad
  localparam logic [1:0] TRI_ORDER [6] = '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2};

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [8:0]         u;
    logic [7:0]         v;
    logic [31:0]        color;
    logic [15:0]        idx;
    logic               last;
  } glyph_item_t;

  typedef struct packed {
    logic [7:0]  text;
    logic        typed;
    glyph_item_t first;
  } text_row_t;

  localparam glyph_item_t UNTYPED = '0;
  localparam int N_DIRECTED = 28;

  // directed text: reset extremes, every decoder path, zero inside sequences
  localparam text_row_t DIRECTED_TEXT [N_DIRECTED] = '{
    '{8'h00, 1'b1, glyph_item_t'{KIND_EXTENT, 32'sh0, 32'shFFF8_0000, 32'sh0,
                                 9'd0, 8'd0, 32'h0, 16'd0, 1'b1}},
    '{8'h41, 1'b1, glyph_item_t'{KIND_VERTEX, 32'sh0, 32'sh0, 32'sh0,
                                 9'd16, 8'd48, 32'hFFFF_FFFF, 16'd0, 1'b0}},
    '{8'h80, 1'b1, glyph_item_t'{KIND_VERTEX, 32'sh0008_0000, 32'sh0, 32'sh0,
                                 9'd0, 8'd8, 32'hFFFF_FFFF, 16'd4, 1'b0}},
    '{8'h01, 1'b0, UNTYPED}, '{8'h7F, 1'b0, UNTYPED}, '{8'h0A, 1'b0, UNTYPED},
    '{8'hC4, 1'b0, UNTYPED}, '{8'h80, 1'b0, UNTYPED},
    '{8'hC4, 1'b0, UNTYPED}, '{8'h81, 1'b0, UNTYPED},
    '{8'hE0, 1'b0, UNTYPED}, '{8'h81, 1'b0, UNTYPED}, '{8'h81, 1'b0, UNTYPED},
    '{8'hC3, 1'b0, UNTYPED}, '{8'h0A, 1'b0, UNTYPED},
    '{8'hF7, 1'b0, UNTYPED}, '{8'hBF, 1'b0, UNTYPED}, '{8'hBF, 1'b0, UNTYPED},
    '{8'hBF, 1'b0, UNTYPED},
    '{8'hE2, 1'b0, UNTYPED}, '{8'h80, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED},
    '{8'hDF, 1'b0, UNTYPED}, '{8'hBF, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED},
    '{8'hBF, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED}
  };

  logic clk;
  logic rst;

  tgq_byte_if in_if();
  tgq_out_if  out_if();
  tgq_cfg_if  cfg_if();

  text_glyph_quad_generator i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .cfg (cfg_if),
    .out (out_if)
  );

  // mirror of the registers and text layout state
  logic signed [31:0] org_x, org_y, org_z;
  logic [30:0]        gsize;
  logic [31:0]        gcolor;
  logic signed [31:0] cur_x, cur_y, line_w, widest, ext_h;
  logic [15:0]        vcount;
  logic [1:0]         seq_left;
  logic [20:0]        seq_code;

  glyph_item_t quad_results_q[$];
  glyph_item_t new_results[$];
  logic [7:0]  text_q[$];

  int n_err;
  int n_bytes;
  int n_checked;
  int n_settings;
  int snd_pct;
  int rcv_pct;
  int cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp to the signed q16.16 range
  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > Q_MAX) return 32'sh7FFF_FFFF;
    if (v < Q_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // fold the current line into the text extent
  function automatic void close_line();
    if (line_w > widest) widest = line_w;
    ext_h  = clamp_q16(longint'(ext_h) - longint'(gsize));
    line_w = '0;
  endfunction

  // four vertices and six indices of one glyph at the cursor
  function automatic void push_glyph(input logic [20:0] code);
    logic [20:0]        c;
    logic [8:0]         u0, u1;
    logic [7:0]         v0, v1;
    logic signed [31:0] x1, y1;
    c  = (code > MAX_GLYPH) ? 21'd0 : code;
    u0 = 9'(c[3:0] * CELL_W);
    u1 = 9'(u0 + CELL_W);
    v1 = 8'(c[8:4] * ROW_PITCH);
    v0 = 8'(v1 + ROW_INK);
    x1 = clamp_q16(longint'(cur_x) + longint'(gsize));
    y1 = clamp_q16(longint'(cur_y) + longint'(gsize));
    new_results.push_back(glyph_item_t'{KIND_VERTEX, cur_x, cur_y, org_z, u0, v0, gcolor,
                                        vcount, 1'b0});
    new_results.push_back(glyph_item_t'{KIND_VERTEX, cur_x, y1, org_z, u0, v1, gcolor,
                                        16'(vcount + 16'd1), 1'b0});
    new_results.push_back(glyph_item_t'{KIND_VERTEX, x1, y1, org_z, u1, v1, gcolor,
                                        16'(vcount + 16'd2), 1'b0});
    new_results.push_back(glyph_item_t'{KIND_VERTEX, x1, cur_y, org_z, u1, v0, gcolor,
                                        16'(vcount + 16'd3), 1'b0});
    for (int i = 0; i < 6; i++) begin
      new_results.push_back(glyph_item_t'{KIND_INDEX, 32'sh0, 32'sh0, 32'sh0, 9'd0, 8'd0,
                                          32'h0, 16'(vcount + TRI_ORDER[i]), i == 5});
    end
    vcount = 16'(vcount + 16'd4);
    cur_x  = x1;
    line_w = clamp_q16(longint'(line_w) + longint'(gsize));
  endfunction

  // decode one text byte and collect the result items it causes
  function automatic void predict_text_byte(input logic [7:0] b);
    new_results.delete();
    if (b == BYTE_END) begin
      close_line();
      new_results.push_back(glyph_item_t'{KIND_EXTENT, widest, ext_h, 32'sh0, 9'd0, 8'd0,
                                          32'h0, 16'd0, 1'b1});
      cur_x    = org_x;
      cur_y    = org_y;
      line_w   = '0;
      widest   = '0;
      ext_h    = '0;
      seq_left = '0;
      seq_code = '0;
    end else if (seq_left != 2'd0) begin
      // any nonzero byte continues an open sequence
      seq_code = {seq_code[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        push_glyph(seq_code);
        seq_code = '0;
      end
    end else if (b == BYTE_NEWLINE) begin
      cur_y = clamp_q16(longint'(cur_y) - longint'(gsize));
      cur_x = org_x;
      close_line();
    end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
      seq_code = 21'(b[2:0]);
      seq_left = 2'd3;
    end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
      seq_code = 21'(b[3:0]);
      seq_left = 2'd2;
    end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
      seq_code = 21'(b[4:0]);
      seq_left = 2'd1;
    end else if ((b & LEAD2_MASK) == CONT_CODE) begin
      // stray continuation byte
      push_glyph(21'd0);
    end else begin
      push_glyph(21'(b));
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  // send one text byte, idling first at random, and record its results
  task automatic send_byte(input logic [7:0] b, input logic typed, input glyph_item_t first);
    if ($urandom_range(99) < snd_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_text_byte(b);
    if (typed) new_results[0] = first;
    foreach (new_results[i]) quad_results_q.push_back(new_results[i]);
    n_bytes++;
  endtask

  // hold the sender until every expected item has arrived and the block has settled
  task automatic drain_block();
    in_if.valid <= 1'b0;
    while (quad_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X: begin
        org_x = data;
        cur_x = data;
      end
      REG_ORIGIN_Y: begin
        org_y = data;
        cur_y = data;
      end
      REG_ORIGIN_Z:    org_z  = data;
      REG_GLYPH_SIZE:  gsize  = data[30:0];
      REG_GLYPH_COLOR: gcolor = data;
      default: ;
    endcase
  endtask

  // random text: mostly well-formed utf-8 with some noise and broken sequences
  task automatic add_random_text(input int want);
    int pick;
    while (text_q.size() < want) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 48) begin
        if ($urandom_range(1)) text_q.push_back(8'($urandom_range(8'hC0, 8'hC4)));
        else text_q.push_back(8'hC0 | 8'($urandom_range(31)));
        text_q.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (pick < 56) begin
        text_q.push_back(8'hE0 | 8'($urandom_range(15)));
        repeat (2) text_q.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (pick < 62) begin
        text_q.push_back(8'hF0 | 8'($urandom_range(15)));
        repeat (3) text_q.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (pick < 70) begin
        text_q.push_back(BYTE_NEWLINE);
      end else if (pick < 75) begin
        text_q.push_back(8'h80 | 8'($urandom_range(63)));
      end else if (pick < 80) begin
        text_q.push_back(BYTE_END);
      end else if (pick < 87) begin
        // lead byte cut short by an end or another lead
        text_q.push_back(8'hC0 | 8'($urandom_range(63)));
        if ($urandom_range(1)) text_q.push_back(BYTE_END);
        else text_q.push_back(8'hC0 | 8'($urandom_range(63)));
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // receiver ready, stalled at random
  always @(posedge clk) begin
    out_if.ready <= !rst && ($urandom_range(99) >= rcv_pct);
  end

  // compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : result_check
    glyph_item_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (quad_results_q.size() == 0) begin
        $error("result item with nothing expected: kind %0d", out_if.item_kind);
        n_err++;
      end else begin
        want = quad_results_q.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(out_if.item_kind));
        check_field("pos_x", want.x, out_if.pos_x);
        check_field("pos_y", want.y, out_if.pos_y);
        check_field("pos_z", want.z, out_if.pos_z);
        check_field("tex_u", 32'(want.u), 32'(out_if.tex_u));
        check_field("tex_v", 32'(want.v), 32'(out_if.tex_v));
        check_field("vertex_color", want.color, out_if.vertex_color);
        check_field("index_value", 32'(want.idx), 32'(out_if.index_value));
        check_field("last", 32'(want.last), 32'(out_if.last));
        n_checked++;
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d items still expected", cycle_count,
             quad_results_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] vx, vy, vz, vs, vc;
    rst              = 1'b1;
    in_if.valid      = 1'b0;
    in_if.text_byte  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    n_err            = 0;
    n_bytes          = 0;
    n_checked        = 0;
    n_settings       = 1;
    snd_pct          = 9;
    rcv_pct          = 54;
    org_x            = '0;
    org_y            = '0;
    org_z            = '0;
    gsize            = GLYPH_SIZE_RST;
    gcolor           = GLYPH_COLOR_RST;
    cur_x            = '0;
    cur_y            = '0;
    line_w           = '0;
    widest           = '0;
    ext_h            = '0;
    vcount           = '0;
    seq_left         = '0;
    seq_code         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed text under the reset settings
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_byte(DIRECTED_TEXT[r].text, DIRECTED_TEXT[r].typed, DIRECTED_TEXT[r].first);
    end

    // random text, one setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      snd_pct = (ph < 2) ? 9 : (ph < 4) ? 54 : 0;
      rcv_pct = (ph < 2) ? 54 : (ph < 4) ? 9 : 0;
      drain_block();
      case (ph)
        0: begin
          vx = 32'h7FFF_0000; vy = 32'h8000_0000; vz = 32'h7FFF_FFFF;
          vs = 32'h7FFF_FFFF; vc = 32'h0;
        end
        1: begin
          vx = 32'h8000_0000; vy = 32'h7FFF_FFFF; vz = 32'h8000_0000;
          vs = 32'h8000_0000; vc = $urandom;
        end
        default: begin
          vx = $urandom; vy = $urandom; vz = $urandom;
          vs = {1'($urandom), 31'($urandom_range(0, 32'h0010_0000))};
          vc = $urandom;
        end
      endcase
      cfg_write(REG_ORIGIN_X, vx);
      cfg_write(REG_ORIGIN_Y, vy);
      cfg_write(REG_ORIGIN_Z, vz);
      cfg_write(REG_GLYPH_SIZE, vs);
      cfg_write(REG_GLYPH_COLOR, vc);
      cfg_if.valid <= 1'b0;
      n_settings++;
      text_q.delete();
      add_random_text(PHASE_BYTES);
      text_q.push_back(BYTE_END);
      for (int k = 0; k < text_q.size(); k++) begin
        // one pause mid-stream until the block has caught up
        if (ph == 3 && k == text_q.size() / 2) drain_block();
        send_byte(text_q[k], 1'b0, UNTYPED);
      end
    end

    drain_block();
    $display("sent %0d text bytes under %0d register settings", n_bytes, n_settings);
    $display("checked %0d result items (vertices, indices, extents)", n_checked);
    if (n_err == 0 && quad_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/tgq_pkg.sv
hdl/tgq_if.sv
hdl/tgq_decoder.sv
hdl/tgq_cmd_fifo.sv
hdl/tgq_emitter.sv
hdl/text_glyph_quad_generator.sv
sim/tb_text_glyph_quad_generator.sv
